>>> design/pbrle_pkg.sv
package pbrle_pkg;

    localparam logic [15:0] BUFFER_LIMIT = 16'd28800;  // 1440*20

    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_REPEAT  = 2'd1;
    localparam logic [1:0] MODE_LITERAL = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_TRUNC    = 2'd2;

    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam logic REG_MAX_OUTPUT = 1'b0;

    // Everything one item causes: an optional run and an optional summary.
    typedef struct packed {
        logic        has_run;
        logic        has_sum;
        logic [7:0]  value;
        logic [7:0]  run_length;
        logic [15:0] total_count;
        logic [1:0]  status;
    } entry_t;

endpackage

>>> design/pbrle_front.sv
module pbrle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [15:0]         max_output,
    input  logic                q_full,
    output logic                push,
    output pbrle_pkg::entry_t   entry
);
    import pbrle_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  literal_left_reg, literal_left_next;
    logic [7:0]  repeat_total_reg, repeat_total_next;
    logic [15:0] out_count_reg, out_count_next;
    logic        stopped_reg, stopped_next;

    logic        accept;
    logic [15:0] lim;
    logic        stop0;
    logic [7:0]  want;
    logic [15:0] room;
    logic [7:0]  run_len;
    logic [15:0] count1;
    logic        stop1;
    logic        emit;
    logic [7:0]  lit_dec;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign lim      = (max_output > BUFFER_LIMIT) ? BUFFER_LIMIT : max_output;
    assign stop0    = stopped_reg || (out_count_reg >= lim);
    assign emit     = !stop0 && (mode_reg == MODE_REPEAT || mode_reg == MODE_LITERAL);
    assign want     = (mode_reg == MODE_REPEAT) ? repeat_total_reg : 8'd1;
    assign room     = lim - out_count_reg;
    assign run_len  = (room < {8'd0, want}) ? room[7:0] : want;
    assign count1   = emit ? out_count_reg + {8'd0, run_len} : out_count_reg;
    assign stop1    = stop0 || (count1 >= lim);
    assign lit_dec  = (literal_left_reg != 8'd0) ? literal_left_reg - 8'd1 : 8'd0;

    always_comb
    begin
        mode_next         = mode_reg;
        literal_left_next = literal_left_reg;
        repeat_total_next = repeat_total_reg;
        if (!stop0)
        begin
            unique case (mode_reg)
                MODE_REPEAT:
                begin
                    repeat_total_next = 8'd0;
                    mode_next         = MODE_HEADER;
                end
                MODE_LITERAL:
                begin
                    literal_left_next = lit_dec;
                    if (lit_dec == 8'd0)
                    begin
                        mode_next = MODE_HEADER;
                    end
                end
                default:
                begin
                    if (data_byte[7])
                    begin
                        repeat_total_next = 8'(9'd257 - {1'b0, data_byte});
                        mode_next         = MODE_REPEAT;
                    end
                    else
                    begin
                        literal_left_next = data_byte + 8'd1;
                        mode_next         = MODE_LITERAL;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        entry.has_run     = emit;
        entry.has_sum     = last_byte;
        entry.value       = data_byte;
        entry.run_length  = run_len;
        entry.total_count = count1;
        if (stop1)
        begin
            entry.status = STATUS_OVERFLOW;
        end
        else if (mode_next == MODE_REPEAT || mode_next == MODE_LITERAL)
        begin
            entry.status = STATUS_TRUNC;
        end
        else
        begin
            entry.status = STATUS_OK;
        end
    end

    assign push         = accept && (emit || last_byte);
    assign out_count_next = count1;
    assign stopped_next   = stop1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_HEADER;
            literal_left_reg <= 8'd0;
            repeat_total_reg <= 8'd0;
            out_count_reg    <= 16'd0;
            stopped_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                mode_reg         <= MODE_HEADER;
                literal_left_reg <= 8'd0;
                repeat_total_reg <= 8'd0;
                out_count_reg    <= 16'd0;
                stopped_reg      <= 1'b0;
            end
            else
            begin
                mode_reg         <= mode_next;
                literal_left_reg <= literal_left_next;
                repeat_total_reg <= repeat_total_next;
                out_count_reg    <= out_count_next;
                stopped_reg      <= stopped_next;
            end
        end
    end

endmodule

>>> design/pbrle_queue.sv
module pbrle_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pbrle_pkg::entry_t  push_entry,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output pbrle_pkg::entry_t  head
);
    import pbrle_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

>>> design/pbrle_back.sv
module pbrle_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  pbrle_pkg::entry_t  q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [7:0]         value,
    output logic [7:0]         run_length,
    output logic [15:0]        total_count,
    output logic [1:0]         status,
    output logic               last_result
);
    import pbrle_pkg::*;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  value_reg;
    logic [7:0]  run_length_reg;
    logic [15:0] total_count_reg;
    logic [1:0]  status_reg;
    logic        last_result_reg;

    // summary held back behind a run of the same item
    logic        sum_pend_reg;
    logic [15:0] sum_total_reg;
    logic [1:0]  sum_status_reg;

    logic        load;

    assign load  = !out_valid_reg || !out_stall;
    assign q_pop = load && !sum_pend_reg && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (sum_pend_reg)
            begin
                out_valid_reg <= 1'b1;
                sum_pend_reg  <= 1'b0;
            end
            else if (q_not_empty)
            begin
                out_valid_reg <= 1'b1;
                sum_pend_reg  <= q_head.has_run && q_head.has_sum;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sum_pend_reg)
            begin
                kind_reg        <= KIND_SUMMARY;
                value_reg       <= 8'd0;
                run_length_reg  <= 8'd0;
                total_count_reg <= sum_total_reg;
                status_reg      <= sum_status_reg;
                last_result_reg <= 1'b1;
            end
            else if (q_not_empty)
            begin
                sum_total_reg  <= q_head.total_count;
                sum_status_reg <= q_head.status;
                if (q_head.has_run)
                begin
                    kind_reg        <= KIND_RUN;
                    value_reg       <= q_head.value;
                    run_length_reg  <= q_head.run_length;
                    total_count_reg <= q_head.total_count;
                    status_reg      <= STATUS_OK;
                    last_result_reg <= !q_head.has_sum;
                end
                else
                begin
                    kind_reg        <= KIND_SUMMARY;
                    value_reg       <= 8'd0;
                    run_length_reg  <= 8'd0;
                    total_count_reg <= q_head.total_count;
                    status_reg      <= q_head.status;
                    last_result_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign value       = value_reg;
    assign run_length  = run_length_reg;
    assign total_count = total_count_reg;
    assign status      = status_reg;
    assign last_result = last_result_reg;

endmodule

>>> design/packbits_run_length_decoder_unit.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    data_byte, last_byte
// out      output     out_valid/out_stall  kind, value, run_length, total_count,
//                                          status, last_result
// cfg      input      APB psel/penable     max_output at byte address 0
//
// One compressed byte accepted per cycle while the 4-entry item queue has room.
// Each result leaves through a registered output stage, one per cycle while
// out_stall is low; a byte that yields a run and a summary holds the output
// stage for the run, then the summary. Each item is queued before that stage.
// rst_n clears decoder state, queue pointers and output valid; max_output resets
// to 28800. in_stall is high only while the queue is full.
module packbits_run_length_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [7:0]                    value,
    output logic [7:0]                    run_length,
    output logic [15:0]                   total_count,
    output logic [1:0]                    status,
    output logic                          last_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbrle_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pbrle_pkg::*;

    logic [15:0] max_output_reg;
    logic        cfg_wr;
    logic        push;
    entry_t      push_entry;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    entry_t      q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_OUTPUT);
    assign prdata = (paddr[2] == REG_MAX_OUTPUT) ? {16'd0, max_output_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_output_reg <= BUFFER_LIMIT;
        end
        else if (cfg_wr)
        begin
            max_output_reg <= pwdata[15:0];
        end
    end

    pbrle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .max_output (max_output_reg),
        .q_full     (q_full),
        .push       (push),
        .entry      (push_entry)
    );

    pbrle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    pbrle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .run_length  (run_length),
        .total_count (total_count),
        .status      (status),
        .last_result (last_result)
    );

endmodule
